// ----- rtl/cdq_pkg.sv -----
// shared constants, action codes and ring index helpers for the circular deque
`default_nettype none

package cdq_pkg;

  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CAP_W  = 11;
  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(1024);
  localparam logic [CAP_W-1:0]  CAP_MIN   = CAP_W'(2);
  localparam logic [CAP_W-1:0]  CAP_MAX   = CAP_W'(DEPTH);
  localparam logic [DATA_W-1:0] NEG_ONE   = '1;

  localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd4;

  // clamp the programmed capacity into 2..DEPTH
  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    r = c;
    if (c < CAP_MIN) r = CAP_MIN;
    if (c > CAP_MAX) r = CAP_MAX;
    return r;
  endfunction

  // next index forward, wraps to zero at the end of the used ring
  function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i,
                                                input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] nx;
    nx = CAP_W'(i) + CAP_W'(1);
    return (nx < c) ? nx[IDX_W-1:0] : '0;
  endfunction

  // next index backward, wraps to capacity-1
  function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] cm1;
    cm1 = c - CAP_W'(1);
    return (i == '0 || CAP_W'(i) > c) ? cm1[IDX_W-1:0] : i - IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cdq_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/circular_deque_core.sv -----
// circular deque top level: ring memory, index control and result register
//
//  channel  ports                                 handshake
//  -------  ------------------------------------  ---------------------------
//  input    in_action, in_value                   start high, busy low
//  result   out_done_res, out_popped,             out_valid strobe, one cycle,
//           out_front_value, out_rear_value,      no back-pressure
//           out_is_empty, out_is_full
//  config   cfg_capacity                          cfg_valid and cfg_ready
//
// an item has an accept cycle and a read cycle: the accept cycle updates the
// indices, writes a pushed element and addresses the ring; the read cycle after
// it takes the registered memory read (new front after a front pop, new rear
// after a rear pop) and loads the result register and the out_valid strobe
// busy is high during that read cycle only, so no new item is taken before the
// last one has loaded its result; reset (synchronous, rst_n low) empties the
// deque and sets capacity to 1024; ring contents are not cleared: the user must
// see that an entry is only read once written; the block does not enforce it

`default_nettype none

module circular_deque_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input item
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cdq_pkg::ACT_W-1:0]     in_action,
  input  wire logic signed [cdq_pkg::DATA_W-1:0] in_value,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cdq_pkg::CAP_W-1:0]     cfg_capacity,
  // result item
  output logic                               out_valid,
  output logic                               out_done_res,
  output logic signed [cdq_pkg::DATA_W-1:0]  out_popped,
  output logic signed [cdq_pkg::DATA_W-1:0]  out_front_value,
  output logic signed [cdq_pkg::DATA_W-1:0]  out_rear_value,
  output logic                               out_is_empty,
  output logic                               out_is_full
);

  import cdq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state_r, state_nxt;

  // deque state
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic              empty_r, empty_nxt;
  logic [CAP_W-1:0]  cap_r;
  // cached copies of the entries at head and tail
  logic [DATA_W-1:0] front_r, front_nxt;
  logic [DATA_W-1:0] rear_r, rear_nxt;

  // per-item pending info carried into the read cycle
  logic              done_r, done_nxt;
  logic [DATA_W-1:0] popped_r, popped_nxt;
  logic              ld_front_r, ld_front_nxt;
  logic              ld_rear_r, ld_rear_nxt;

  // result register
  logic              out_valid_r;
  logic              out_done_r;
  logic [DATA_W-1:0] out_popped_r, out_front_r, out_rear_r;
  logic              out_empty_r, out_full_r;

  // ring memory ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CAP_W-1:0]  cap_used;
  logic              full_now;
  logic              accept;
  logic [DATA_W-1:0] front_fin, rear_fin;

  assign cap_used  = clamp_cap(cap_r);
  assign busy      = (state_r == ST_READ);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;
  assign full_now  = ~empty_r && (tail_r == step_back(head_r, cap_used));

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // accept cycle: work out the action against the current state
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    empty_nxt    = empty_r;
    front_nxt    = front_r;
    rear_nxt     = rear_r;
    done_nxt     = done_r;
    popped_nxt   = popped_r;
    ld_front_nxt = ld_front_r;
    ld_rear_nxt  = ld_rear_r;
    state_nxt    = state_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = in_value;
    ram_raddr    = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          done_nxt     = 1'b0;
          popped_nxt   = NEG_ONE;
          ld_front_nxt = 1'b0;
          ld_rear_nxt  = 1'b0;
          state_nxt    = ST_READ;
          case (in_action)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
              if (!full_now) begin
                done_nxt = 1'b1;
                ram_we   = 1'b1;
                if (empty_r) begin
                  // first element always lands in entry zero
                  head_nxt  = '0;
                  tail_nxt  = '0;
                  empty_nxt = 1'b0;
                  front_nxt = in_value;
                  rear_nxt  = in_value;
                  ram_waddr = '0;
                end else if (in_action == ACT_PUSH_FRONT) begin
                  head_nxt  = step_back(head_r, cap_used);
                  front_nxt = in_value;
                  ram_waddr = head_nxt;
                end else begin
                  tail_nxt  = step_fwd(tail_r, cap_used);
                  rear_nxt  = in_value;
                  ram_waddr = tail_nxt;
                  // after a capacity cut the new tail can land on the head entry
                  if (tail_nxt == head_r) front_nxt = in_value;
                end
              end
            end
            ACT_POP_FRONT: begin
              if (!empty_r) begin
                done_nxt   = 1'b1;
                popped_nxt = front_r;
                if (head_r == tail_r) begin
                  empty_nxt = 1'b1;
                end else begin
                  head_nxt     = step_fwd(head_r, cap_used);
                  ld_front_nxt = 1'b1;
                  ram_raddr    = head_nxt;
                end
              end
            end
            ACT_POP_REAR: begin
              if (!empty_r) begin
                done_nxt   = 1'b1;
                popped_nxt = rear_r;
                if (head_r == tail_r) begin
                  empty_nxt = 1'b1;
                end else begin
                  tail_nxt    = step_back(tail_r, cap_used);
                  ld_rear_nxt = 1'b1;
                  ram_raddr   = tail_nxt;
                end
              end
            end
            default: begin
              // no operation, unused codes included
            end
          endcase
        end
      end
      ST_READ: begin
        // memory data for the new front or rear is here now
        if (ld_front_r) front_nxt = ram_rdata;
        if (ld_rear_r)  rear_nxt  = ram_rdata;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign front_fin = ld_front_r ? ram_rdata : front_r;
  assign rear_fin  = ld_rear_r  ? ram_rdata : rear_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      cap_r       <= CAP_RESET;
      ld_front_r  <= 1'b0;
      ld_rear_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      ld_front_r  <= ld_front_nxt;
      ld_rear_r   <= ld_rear_nxt;
      out_valid_r <= (state_r == ST_READ);
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    front_r  <= front_nxt;
    rear_r   <= rear_nxt;
    done_r   <= done_nxt;
    popped_r <= popped_nxt;
    if (state_r == ST_READ) begin
      out_done_r   <= done_r;
      out_popped_r <= popped_r;
      out_front_r  <= empty_r ? NEG_ONE : front_fin;
      out_rear_r   <= empty_r ? NEG_ONE : rear_fin;
      out_empty_r  <= empty_r;
      out_full_r   <= full_now;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_done_res    = out_done_r;
  assign out_popped      = out_popped_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for circular_deque_core: directed items, then random phases per capacity
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  // action codes that the block treats as no operation
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

  localparam int IDLE_LIMIT      = 2000;  // cycles with no handshake of any kind
  localparam int SETTLE_CYCLES   = 4;     // settle time after the results are drained
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 56;

  // bias of the random action mix within one phase
  localparam int BIAS_PUSH = 0;
  localparam int BIAS_EVEN = 1;
  localparam int BIAS_POP  = 2;

  typedef struct {
    logic                     done_res;
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } deque_status_t;

  // deque predictor and store of expected status items
  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring [DEPTH];
    bit                       written [DEPTH];
    logic [IDX_W-1:0]         head = '0;
    logic [IDX_W-1:0]         tail = '0;
    bit                       empty = 1'b1;
    logic [CAP_W-1:0]         capacity = CAP_RESET;
    deque_status_t            expected_q [$];
    int unsigned              mismatches = 0;

    function int unsigned used_cap();
      if (capacity < CAP_MIN) return CAP_MIN;
      if (capacity > CAP_MAX) return CAP_MAX;
      return capacity;
    endfunction

    function logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] i);
      int unsigned ii;
      ii = i;
      if (ii + 1 < used_cap()) return i + 1'b1;
      return '0;
    endfunction

    // an index beyond the capacity also wraps to the last slot
    function logic [IDX_W-1:0] ring_prev(logic [IDX_W-1:0] i);
      int unsigned ii;
      ii = i;
      if (ii == 0 || ii > used_cap()) return IDX_W'(used_cap() - 1);
      return i - 1'b1;
    endfunction

    function bit ring_full();
      return !empty && tail == ring_prev(head);
    endfunction

    // true if a pop would leave an end on a slot never written since reset
    function bit pop_hits_unwritten(logic [ACT_W-1:0] act);
      if (empty || head == tail) return 1'b0;
      if (act == ACT_POP_FRONT) return !written[ring_next(head)];
      if (act == ACT_POP_REAR) return !written[ring_prev(tail)];
      return 1'b0;
    endfunction

    function void store(logic [IDX_W-1:0] i, logic signed [DATA_W-1:0] val);
      ring[i] = val;
      written[i] = 1'b1;
    endfunction

    function void note_item(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] val);
      deque_status_t want;
      want.done_res = 1'b0;
      want.popped = NEG_ONE;
      if (act == ACT_PUSH_FRONT || act == ACT_PUSH_REAR) begin
        if (!ring_full()) begin
          if (empty) begin
            head = '0;
            tail = '0;
            empty = 1'b0;
            store('0, val);
          end else if (act == ACT_PUSH_FRONT) begin
            head = ring_prev(head);
            store(head, val);
          end else begin
            tail = ring_next(tail);
            store(tail, val);
          end
          want.done_res = 1'b1;
        end
      end else if (act == ACT_POP_FRONT || act == ACT_POP_REAR) begin
        if (!empty) begin
          want.done_res = 1'b1;
          if (act == ACT_POP_FRONT) begin
            want.popped = ring[head];
            if (head == tail) empty = 1'b1;
            else head = ring_next(head);
          end else begin
            want.popped = ring[tail];
            if (head == tail) empty = 1'b1;
            else tail = ring_prev(tail);
          end
        end
      end
      want.front_value = empty ? NEG_ONE : ring[head];
      want.rear_value = empty ? NEG_ONE : ring[tail];
      want.is_empty = empty;
      want.is_full = ring_full();
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic signed [DATA_W-1:0] want,
                                logic signed [DATA_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_result(deque_status_t got);
      deque_status_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $error("result strobe with no item outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("popped", want.popped, got.popped);
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("rear_value", want.rear_value, got.rear_value);
      compare_field("is_empty", want.is_empty, got.is_empty);
      compare_field("is_full", want.is_full, got.is_full);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic [ACT_W-1:0]         in_action = ACT_NONE;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     cfg_valid = 1'b0;
  logic [CAP_W-1:0]         cfg_capacity = CAP_RESET;

  logic                     busy;
  logic                     cfg_ready;
  logic                     out_valid;
  logic                     out_done_res;
  logic signed [DATA_W-1:0] out_popped;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_rear_value;
  logic                     out_is_empty;
  logic                     out_is_full;

  deque_scoreboard sb;
  int unsigned     idle_cycles = 0;

  circular_deque_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_value        (in_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity),
    .out_valid       (out_valid),
    .out_done_res    (out_done_res),
    .out_popped      (out_popped),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // every strobed status item is checked against the oldest expectation
  always @(posedge clk) begin : watch_results
    deque_status_t seen;
    if (rst_n && out_valid) begin
      seen.done_res = out_done_res;
      seen.popped = out_popped;
      seen.front_value = out_front_value;
      seen.rear_value = out_rear_value;
      seen.is_empty = out_is_empty;
      seen.is_full = out_is_full;
      sb.check_result(seen);
    end
  end

  // watchdog: any accepted item, result or register write restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // gap before an item: mostly none or short, now and then long
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // element values: mostly random, sometimes zero, the extremes and -1
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: return '0;
        1: return NEG_ONE;
        2: return 32'sh7FFF_FFFF;
        default: return 32'sh8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(int bias);
    int unsigned r;
    int unsigned push_pct;
    r = $urandom_range(99);
    if (r < 6) begin
      case ($urandom_range(3))
        0: return ACT_NONE;
        1: return ACT_SPARE_A;
        2: return ACT_SPARE_B;
        default: return ACT_SPARE_C;
      endcase
    end
    push_pct = (bias == BIAS_PUSH) ? 66 : (bias == BIAS_POP) ? 34 : 50;
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
    return $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_REAR;
  endfunction

  // present one item and hold it until the block takes it; start stays high
  // afterwards so a following item with no gap goes straight in
  task automatic send_item(input logic [ACT_W-1:0] act,
                           input logic signed [DATA_W-1:0] val, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_value <= val;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_item(act, val);
  endtask

  // a pop that would walk onto a never-written slot (possible after a
  // capacity change with items held) becomes a push at the same end
  task automatic random_item(input int bias, input bit burst);
    logic [ACT_W-1:0] act;
    act = pick_action(bias);
    if (sb.pop_hits_unwritten(act))
      act = (act == ACT_POP_FRONT) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
    send_item(act, pick_value(), burst ? 0 : gap_len());
  endtask

  // sender holds off until every expected status item has arrived
  task automatic drain_results();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.capacity = cap;
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] cap_plan [PHASES];
    int               bias;
    bit               burst;

    sb = new;
    // capacities: the clamped ends (0, 1, above DEPTH), the true ends and small rings
    cap_plan = '{11'd2, 11'd0, 11'd4, 11'd1, 11'd1024, 11'd3,
                 11'd2047, 11'd6, 11'd1025, 11'd9, 11'd2, 11'd5};
    cap_plan[PHASES-1] = CAP_W'($urandom_range(32, 2));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on a three-slot ring
    write_capacity(11'd3);
    send_item(ACT_POP_FRONT, 32'sd7, 0);              // pop when empty
    send_item(ACT_POP_REAR, 32'sd7, 1);
    send_item(ACT_NONE, 32'sh7FFF_FFFF, 0);
    send_item(ACT_SPARE_A, 32'sd1, 2);                // unused codes do nothing
    send_item(ACT_SPARE_B, 32'sd1, 0);
    send_item(ACT_SPARE_C, 32'sh8000_0000, 0);
    send_item(ACT_PUSH_REAR, 32'sh7FFF_FFFF, 0);      // push into empty deque
    send_item(ACT_PUSH_FRONT, 32'sh8000_0000, 3);
    send_item(ACT_PUSH_REAR, NEG_ONE, 0);             // now full
    send_item(ACT_PUSH_FRONT, 32'sd0, 0);             // refused when full
    send_item(ACT_PUSH_REAR, 32'sd12345, 1);
    send_item(ACT_POP_FRONT, 32'sd0, 0);
    send_item(ACT_POP_REAR, 32'sd0, 0);
    send_item(ACT_POP_REAR, 32'sd0, 5);               // last element leaves
    send_item(ACT_POP_FRONT, 32'sd0, 0);
    send_item(ACT_PUSH_FRONT, 32'sh5555_5555, 0);     // empty again, restarts at slot 0
    send_item(ACT_PUSH_FRONT, 32'shAAAA_AAAA, 0);     // head wraps backwards
    send_item(ACT_PUSH_REAR, 32'sd1, 2);
    send_item(ACT_POP_FRONT, 32'sd0, 0);              // head wraps forwards
    send_item(ACT_POP_FRONT, 32'sd0, 0);
    send_item(ACT_POP_FRONT, 32'sd0, 0);

    // random phases; capacity changes with the deque in whatever state it is
    for (int p = 0; p < PHASES; p++) begin
      bias = $urandom_range(BIAS_POP, BIAS_PUSH);
      burst = ($urandom_range(2) == 0);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_capacity(cap_plan[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(49) == 0) drain_results();
        random_item(bias, burst);
      end
    end

    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_deque_core.sv
tb/testbench.sv
